@@ rtl/plb_pkg.sv @@
// Shared types and codes for the PRP list builder.
// No dependencies; imported by prp_list_builder_core, plb_result_checker and the testbench top.
`timescale 1ns / 1ps
`default_nettype none

package plb_pkg;

    // Request codes carried by s_req_type.
    typedef enum logic {
        REQ_START = 1'b0,
        REQ_PULL  = 1'b1
    } req_type_t;

    // Result codes carried by m_kind.
    typedef enum logic [1:0] {
        KIND_DESC     = 2'd0,
        KIND_LIST     = 2'd1,
        KIND_IDLE     = 2'd2,
        KIND_TOO_BIG  = 2'd3
    } kind_t;

    localparam int ADDR_W   = 64;
    localparam int XFER_W   = 26;
    localparam int OFFSET_W = 16;

endpackage : plb_pkg

`default_nettype wire

@@ rtl/prp_list_builder_core.sv @@
// PRP list builder: descriptor and list word generation for one transfer.
// Depends on plb_pkg (codes and field widths).
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------
//  s_      | in        | s_valid / s_ready  | req_type, buf_addr, xfer_bytes
//  m_      | out       | m_valid / m_ready  | kind, prp_first, prp_second,
//          |           |                    | list_offset, entry_value, is_chain, last
//  cfg_    | in        | cfg_wen            | cfg_wdata (list store address)
//
// Every beat produces exactly one result beat, registered in the cycle after it is accepted.
// A new beat is taken every cycle while the result register is empty or drained
// in the same cycle, so the sustained rate is one beat per clock; the single
// output register is the only storage between the two sides.
// Reset (aresetn low, synchronous) empties the output and clears the list state.
// A stall on m_ready holds the result and deasserts s_ready until it is taken.

module prp_list_builder_core
    import plb_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int LIST_PAGES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_wen,
    input  wire logic [ADDR_W-1:0]   cfg_wdata,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_req_type,
    input  wire logic [ADDR_W-1:0]   s_buf_addr,
    input  wire logic [XFER_W-1:0]   s_xfer_bytes,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [1:0]               m_kind,
    output logic [ADDR_W-1:0]        m_prp_first,
    output logic [ADDR_W-1:0]        m_prp_second,
    output logic [OFFSET_W-1:0]      m_list_offset,
    output logic [ADDR_W-1:0]        m_entry_value,
    output logic                     m_is_chain,
    output logic                     m_last
);

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int SLOTS      = PAGE_BYTES / 8;
    localparam int SLOT_W     = PAGE_SHIFT - 3;
    localparam int LP_W       = (LIST_PAGES > 1) ? $clog2(LIST_PAGES) : 1;
    localparam int CAPACITY   = LIST_PAGES * (SLOTS - 1) + 1;
    localparam int ENT_W      = $clog2(CAPACITY + 1);
    localparam int OFF_FULL_W = LP_W + PAGE_SHIFT;
    // One bit of headroom over the length field for the page arithmetic.
    localparam int LEN_W      = XFER_W + 1;

    // Configuration and list state.
    logic [ADDR_W-1:0]  list_store_reg;
    logic               list_active_reg, list_active_next;
    logic [ADDR_W-1:0]  data_ptr_reg, data_ptr_next;
    logic [ENT_W-1:0]   entries_total_reg, entries_total_next;
    logic [ENT_W-1:0]   entry_index_reg, entry_index_next;
    logic [LP_W-1:0]    list_page_reg, list_page_next;
    logic [SLOT_W-1:0]  page_slot_reg, page_slot_next;

    // Result register.
    logic               out_valid_reg;
    kind_t              kind_reg, kind_next;
    logic [ADDR_W-1:0]  prp_first_reg, prp_first_next;
    logic [ADDR_W-1:0]  prp_second_reg, prp_second_next;
    logic [OFFSET_W-1:0] list_offset_reg, list_offset_next;
    logic [ADDR_W-1:0]  entry_value_reg, entry_value_next;
    logic               is_chain_reg, is_chain_next;
    logic               last_reg, last_next;

    logic               accept;
    logic [LEN_W-1:0]   xfer_len;
    logic [LEN_W-1:0]   head_bytes;
    logic [LEN_W-1:0]   needed_num;
    logic [LEN_W-1:0]   needed;
    logic [ADDR_W-1:0]  next_page;
    logic [ENT_W:0]     entry_index_inc;
    logic [OFF_FULL_W-1:0] off_full;
    logic [ADDR_W-1:0]  chain_ptr;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign xfer_len    = LEN_W'(s_xfer_bytes);
    assign head_bytes  = LEN_W'(PAGE_BYTES) - LEN_W'(s_buf_addr[PAGE_SHIFT-1:0]);
    // Only meaningful when the length reaches past the second page.
    assign needed_num  = xfer_len - head_bytes + LEN_W'(PAGE_BYTES - 1);
    assign needed      = needed_num >> PAGE_SHIFT;
    assign next_page   = {s_buf_addr[ADDR_W-1:PAGE_SHIFT] + 1'b1, {PAGE_SHIFT{1'b0}}};

    assign entry_index_inc = {1'b0, entry_index_reg} + 1'b1;
    // Byte offset is the list page and slot laid side by side over 8-byte words.
    assign off_full  = {list_page_reg, page_slot_reg, 3'b000};
    assign chain_ptr = list_store_reg
                     + ((ADDR_W'(list_page_reg) + 1'b1) << PAGE_SHIFT);

    always_comb begin
        list_active_next   = list_active_reg;
        data_ptr_next      = data_ptr_reg;
        entries_total_next = entries_total_reg;
        entry_index_next   = entry_index_reg;
        list_page_next     = list_page_reg;
        page_slot_next     = page_slot_reg;

        kind_next        = KIND_IDLE;
        prp_first_next   = '0;
        prp_second_next  = '0;
        list_offset_next = '0;
        entry_value_next = '0;
        is_chain_next    = 1'b0;
        last_next        = 1'b0;

        case (req_type_t'(s_req_type))
            REQ_START: begin
                list_active_next = 1'b0;
                if (xfer_len <= head_bytes) begin
                    kind_next      = KIND_DESC;
                    prp_first_next = s_buf_addr;
                    last_next      = 1'b1;
                end else if (xfer_len <= head_bytes + LEN_W'(PAGE_BYTES)) begin
                    kind_next       = KIND_DESC;
                    prp_first_next  = s_buf_addr;
                    prp_second_next = next_page;
                    last_next       = 1'b1;
                end else if (needed > LEN_W'(CAPACITY)) begin
                    kind_next = KIND_TOO_BIG;
                    last_next = 1'b1;
                end else begin
                    list_active_next   = 1'b1;
                    data_ptr_next      = next_page;
                    entries_total_next = ENT_W'(needed);
                    entry_index_next   = '0;
                    list_page_next     = '0;
                    page_slot_next     = '0;
                    kind_next          = KIND_DESC;
                    prp_first_next     = s_buf_addr;
                    prp_second_next    = list_store_reg;
                end
            end
            REQ_PULL: begin
                if (list_active_reg) begin
                    kind_next        = KIND_LIST;
                    list_offset_next = OFFSET_W'(off_full);
                    // The final slot of a page links onward unless the list ends there.
                    if ((&page_slot_reg) &&
                        (entry_index_inc < {1'b0, entries_total_reg})) begin
                        entry_value_next = chain_ptr;
                        is_chain_next    = 1'b1;
                        list_page_next   = list_page_reg + 1'b1;
                        page_slot_next   = '0;
                    end else begin
                        entry_value_next = data_ptr_reg;
                        data_ptr_next    = data_ptr_reg + ADDR_W'(PAGE_BYTES);
                        page_slot_next   = page_slot_reg + 1'b1;
                        entry_index_next = entry_index_inc[ENT_W-1:0];
                        if (entry_index_inc >= {1'b0, entries_total_reg}) begin
                            last_next        = 1'b1;
                            list_active_next = 1'b0;
                        end
                    end
                end
            end
            default: begin
                kind_next = KIND_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_store_reg    <= '0;
            list_active_reg   <= 1'b0;
            data_ptr_reg      <= '0;
            entries_total_reg <= '0;
            entry_index_reg   <= '0;
            list_page_reg     <= '0;
            page_slot_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wen) begin
                list_store_reg <= cfg_wdata;
            end
            if (accept) begin
                list_active_reg   <= list_active_next;
                data_ptr_reg      <= data_ptr_next;
                entries_total_reg <= entries_total_next;
                entry_index_reg   <= entry_index_next;
                list_page_reg     <= list_page_next;
                page_slot_reg     <= page_slot_next;
                out_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg        <= kind_next;
            prp_first_reg   <= prp_first_next;
            prp_second_reg  <= prp_second_next;
            list_offset_reg <= list_offset_next;
            entry_value_reg <= entry_value_next;
            is_chain_reg    <= is_chain_next;
            last_reg        <= last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = kind_reg;
    assign m_prp_first   = prp_first_reg;
    assign m_prp_second  = prp_second_reg;
    assign m_list_offset = list_offset_reg;
    assign m_entry_value = entry_value_reg;
    assign m_is_chain    = is_chain_reg;
    assign m_last        = last_reg;

endmodule : prp_list_builder_core

`default_nettype wire

@@ tb/plb_result_checker.sv @@
// Result checker for prp_list_builder_core: watches the request, result and register ports,
// predicts each result beat and compares it with what the core returns.
// Depends on plb_pkg for the request and result codes.
`timescale 1ns / 1ps

module plb_result_checker
    import plb_pkg::*;
#(
    parameter int PAGE_BYTES = 4096,
    parameter int LIST_PAGES = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wen,
    input  wire logic [ADDR_W-1:0]   cfg_wdata,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_req_type,
    input  wire logic [ADDR_W-1:0]   s_buf_addr,
    input  wire logic [XFER_W-1:0]   s_xfer_bytes,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [1:0]          m_kind,
    input  wire logic [ADDR_W-1:0]   m_prp_first,
    input  wire logic [ADDR_W-1:0]   m_prp_second,
    input  wire logic [OFFSET_W-1:0] m_list_offset,
    input  wire logic [ADDR_W-1:0]   m_entry_value,
    input  wire logic                m_is_chain,
    input  wire logic                m_last,
    output int                       error_count,
    output int                       results_due
);

    localparam bit [63:0] PAGE      = PAGE_BYTES;
    localparam bit [63:0] PAGE_MASK = PAGE_BYTES - 1;
    localparam bit [63:0] SLOTS     = PAGE_BYTES / 8;
    localparam bit [63:0] CAPACITY  = LIST_PAGES * (PAGE_BYTES / 8 - 1) + 1;

    typedef struct {
        kind_t                kind;
        logic [ADDR_W-1:0]    prp_first;
        logic [ADDR_W-1:0]    prp_second;
        logic [OFFSET_W-1:0]  list_offset;
        logic [ADDR_W-1:0]    entry_value;
        logic                 is_chain;
        logic                 last;
    } prp_beat_t;

    prp_beat_t  due_q[$];
    int         errors = 0;

    // Predicted copy of the register and of the list walk.
    bit [63:0]  store_base;
    bit         list_open;
    bit [63:0]  page_base;
    bit [63:0]  words_total;
    bit [63:0]  words_done;
    bit [63:0]  walk_page;
    bit [63:0]  cur_slot;

    assign error_count = errors;

    function automatic prp_beat_t build_result(logic req, logic [63:0] addr,
                                               logic [XFER_W-1:0] bytes);
        prp_beat_t  r;
        bit [63:0]  size;
        bit [63:0]  chunk;
        bit [63:0]  next_page;
        bit [63:0]  needed;
        bit [63:0]  off;
        r = '{kind: KIND_DESC, default: '0};
        if (req == REQ_START) begin
            size      = bytes;
            chunk     = PAGE - (addr & PAGE_MASK);
            next_page = (addr + chunk) & ~PAGE_MASK;
            list_open = 1'b0;
            if (size <= chunk) begin
                r.prp_first = addr;
                r.last      = 1'b1;
            end else if (size <= chunk + PAGE) begin
                r.prp_first  = addr;
                r.prp_second = next_page;
                r.last       = 1'b1;
            end else begin
                needed = (size - chunk + PAGE_MASK) / PAGE;
                if (needed > CAPACITY) begin
                    r.kind = KIND_TOO_BIG;
                    r.last = 1'b1;
                end else begin
                    list_open   = 1'b1;
                    page_base   = next_page;
                    words_total = needed;
                    words_done  = 0;
                    walk_page   = 0;
                    cur_slot    = 0;
                    r.prp_first  = addr;
                    r.prp_second = store_base;
                end
            end
        end else if (!list_open) begin
            r.kind = KIND_IDLE;
        end else begin
            off = walk_page * PAGE + cur_slot * 8;
            r.kind        = KIND_LIST;
            r.list_offset = off[OFFSET_W-1:0];
            // The final slot of a list page points on to the next page, unless
            // the data entry that would sit there is the very last one.
            if (cur_slot == SLOTS - 1 && words_done + 1 < words_total) begin
                r.entry_value = store_base + (walk_page + 1) * PAGE;
                r.is_chain    = 1'b1;
                walk_page++;
                cur_slot = 0;
            end else begin
                r.entry_value = page_base + words_done * PAGE;
                cur_slot++;
                words_done++;
                if (words_done >= words_total) begin
                    r.last    = 1'b1;
                    list_open = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        prp_beat_t want;
        if (!aresetn) begin
            due_q.delete();
            store_base  = '0;
            list_open   = 1'b0;
            page_base   = '0;
            words_total = '0;
            words_done  = '0;
            walk_page   = '0;
            cur_slot    = '0;
        end else begin
            // Compare before pushing, so a request taken at this edge never
            // pairs with a result beat leaving at the same edge.
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    $error("result beat with nothing expected, kind %0d", m_kind);
                    errors++;
                end else begin
                    want = due_q.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("prp_first", want.prp_first, m_prp_first);
                    check_field("prp_second", want.prp_second, m_prp_second);
                    check_field("list_offset", want.list_offset, m_list_offset);
                    check_field("entry_value", want.entry_value, m_entry_value);
                    check_field("is_chain", want.is_chain, m_is_chain);
                    check_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready)
                due_q.push_back(build_result(s_req_type, s_buf_addr, s_xfer_bytes));
            if (cfg_wen)
                store_base = cfg_wdata;
        end
        results_due <= due_q.size();
    end

endmodule

@@ tb/tb_prp_list_builder_core.sv @@
// Testbench top for prp_list_builder_core: drives requests, result back-pressure and
// the list store register, and reports the verdict. Depends on plb_pkg and plb_result_checker.
`timescale 1ns / 1ps

module tb_prp_list_builder_core;
    import plb_pkg::*;

    localparam int        PAGE_BYTES  = 4096;
    localparam int        LIST_PAGES  = 16;
    localparam bit [63:0] PAGE        = PAGE_BYTES;
    localparam bit [63:0] PAGE_MASK   = PAGE_BYTES - 1;
    localparam int        SLOTS       = PAGE_BYTES / 8;
    localparam int        CAPACITY    = LIST_PAGES * (SLOTS - 1) + 1;
    localparam int        XFER_MAX    = (1 << XFER_W) - 1;
    localparam int        RANDOM_GOAL = 550;
    localparam int        STALL_LIMIT = 2000;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_wen       = 1'b0;
    logic [ADDR_W-1:0]   cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_req_type    = REQ_START;
    logic [ADDR_W-1:0]   s_buf_addr    = '0;
    logic [XFER_W-1:0]   s_xfer_bytes  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [1:0]          m_kind;
    logic [ADDR_W-1:0]   m_prp_first;
    logic [ADDR_W-1:0]   m_prp_second;
    logic [OFFSET_W-1:0] m_list_offset;
    logic [ADDR_W-1:0]   m_entry_value;
    logic                m_is_chain;
    logic                m_last;

    int  error_count;
    int  results_due;
    int  beats_sent = 0;
    bit  steady     = 1'b0;

    always #6 aclk = ~aclk;

    prp_list_builder_core #(
        .PAGE_BYTES (PAGE_BYTES),
        .LIST_PAGES (LIST_PAGES)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_buf_addr    (s_buf_addr),
        .s_xfer_bytes  (s_xfer_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_prp_first   (m_prp_first),
        .m_prp_second  (m_prp_second),
        .m_list_offset (m_list_offset),
        .m_entry_value (m_entry_value),
        .m_is_chain    (m_is_chain),
        .m_last        (m_last)
    );

    plb_result_checker #(
        .PAGE_BYTES (PAGE_BYTES),
        .LIST_PAGES (LIST_PAGES)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_buf_addr    (s_buf_addr),
        .s_xfer_bytes  (s_xfer_bytes),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_prp_first   (m_prp_first),
        .m_prp_second  (m_prp_second),
        .m_list_offset (m_list_offset),
        .m_entry_value (m_entry_value),
        .m_is_chain    (m_is_chain),
        .m_last        (m_last),
        .error_count   (error_count),
        .results_due   (results_due)
    );

    always @(posedge aclk)
        m_ready <= steady || ($urandom_range(99) >= 29);

    // Valid is only dropped when a gap is taken, so back-to-back beats never
    // see a lower and a raise in the same step.
    task automatic send_beat(logic req, logic [63:0] addr, logic [XFER_W-1:0] bytes);
        while (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_buf_addr   <= addr;
        s_xfer_bytes <= bytes;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic start_xfer(logic [63:0] addr, int unsigned bytes);
        send_beat(REQ_START, addr, XFER_W'(bytes));
    endtask

    // Pull beats carry junk in the unused fields.
    task automatic pull_words(int n);
        repeat (n) send_beat(REQ_PULL, {$urandom(), $urandom()}, XFER_W'($urandom()));
    endtask

    // Length that needs exactly n list entries after a first chunk of the given size.
    function automatic int unsigned list_bytes(int unsigned chunk, int n);
        return chunk + (n - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES);
    endfunction

    function automatic int unsigned head_room(logic [63:0] addr);
        return 32'(PAGE - (addr & PAGE_MASK));
    endfunction

    // Wait until every expected result has come back, plus the core's latency.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_store(logic [63:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic run_sequence();
        int          pick;
        int          n;
        logic [63:0] addr;
        int unsigned chunk;
        pick  = $urandom_range(99);
        addr  = {$urandom(), $urandom()};
        chunk = head_room(addr);
        if (pick < 10) begin
            pull_words($urandom_range(1, 3));
        end else if (pick < 25) begin
            if ($urandom_range(1))
                start_xfer(addr, $urandom_range(0, chunk));
            else
                start_xfer(addr, $urandom_range(chunk + 1, chunk + PAGE_BYTES));
        end else if (pick < 31) begin
            start_xfer(addr, $urandom_range(chunk + CAPACITY * PAGE_BYTES + 1, XFER_MAX));
        end else if (pick < 35) begin
            start_xfer(addr, $urandom());
        end else begin
            // Now and then a list near one list page long, at times long enough to need a chain pointer.
            if ($urandom_range(14) == 0)
                n = $urandom_range(SLOTS - 7, SLOTS + 20);
            else
                n = $urandom_range(3, 40);
            start_xfer(addr, list_bytes(chunk, n));
            if (pick < 42)
                pull_words($urandom_range(0, n - 1));
            else
                pull_words(n + ((n - 1) / (SLOTS - 1)) + ($urandom_range(3) == 0));
        end
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] addr;
        int          base;
        int          next_cfg;
        int          cfg_pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, with the list store address still at its reset value.
        pull_words(1);
        start_xfer(64'h0, 0);
        start_xfer(64'h1000, PAGE_BYTES);
        start_xfer(64'hFFF, 1);
        start_xfer(64'hFFF, 2);
        start_xfer(64'h1000, 2 * PAGE_BYTES);
        start_xfer(64'h1000, 2 * PAGE_BYTES + 1);
        pull_words(3);
        start_xfer('1, XFER_MAX);
        pull_words(1);
        // The data pages run past the top of the address space.
        start_xfer(64'hFFFF_FFFF_FFFF_E010, 3 * PAGE_BYTES);
        pull_words(3);
        // A new start drops the list in progress.
        start_xfer(64'h0000_0000_0042_0800, 5 * PAGE_BYTES);
        pull_words(2);
        start_xfer(64'h0000_0000_0042_0800, 16);
        pull_words(1);
        start_xfer(64'h0, CAPACITY * PAGE_BYTES + PAGE_BYTES);
        start_xfer(64'h0, CAPACITY * PAGE_BYTES + PAGE_BYTES + 1);
        pull_words(1);
        settle();

        // A list over two list pages, with the register rewritten mid-list
        // so the chain pointer uses the new base and wraps.
        write_store(64'h0000_0040_0000_0000);
        start_xfer(64'h0000_0001_2345_6000, list_bytes(PAGE_BYTES, SLOTS + 1));
        pull_words(300);
        settle();
        write_store(64'hFFFF_FFFF_FFFF_F000);
        pull_words(SLOTS + 1 + 1 - 300 + 1);
        settle();

        // The largest list that fits: the descriptor and the first words.
        write_store('1);
        addr = {$urandom(), $urandom()};
        start_xfer(addr, list_bytes(head_room(addr), CAPACITY));
        pull_words(8);
        settle();
        write_store(64'h0);

        base     = beats_sent;
        next_cfg = base + 200;
        cfg_pick = 0;
        while (beats_sent - base < RANDOM_GOAL) begin
            steady = (beats_sent - base >= 200) && (beats_sent - base < 400);
            if (beats_sent >= next_cfg) begin
                settle();
                case (cfg_pick % 4)
                    0: write_store({$urandom(), $urandom()} & ~PAGE_MASK);
                    1: write_store('1);
                    2: write_store({$urandom(), $urandom()});
                    default: write_store(64'h0);
                endcase
                cfg_pick++;
                next_cfg += 200;
            end
            run_sequence();
        end
        steady = 1'b0;

        settle();
        repeat (4) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
